// ===== rtl/jtag_tap_scan_sequencer_assert.svh =====
// Assertion macros for the JTAG TAP scan sequencer.
// Used by the top level only; no other dependencies.
`ifndef JTAG_TAP_SCAN_SEQUENCER_ASSERT_SVH
`define JTAG_TAP_SCAN_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define JTSS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define JTSS_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define JTSS_ASSERT(lbl, ck, rs, prop, msg)
`define JTSS_ASSERT_NR(lbl, ck, prop, msg)
`endif
`endif

// ===== rtl/jtss_pkg.sv =====
// Shared types and constants for the JTAG TAP scan sequencer.
// No dependencies.
`default_nettype none
package jtss_pkg;

  typedef enum logic [2:0] {
    ACT_RESET = 3'd0,
    ACT_IR    = 3'd1,
    ACT_DR    = 3'd2,
    ACT_PAUSE = 3'd3,
    ACT_IDLE  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_IR,
    SH_DR,
    SH_IDLE
  } shift_kind_t;

  localparam int PRE_W    = 12;
  localparam int PRE_IW   = 4;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int Q_DEPTH  = 2;
  localparam int Q_IW     = $clog2(Q_DEPTH);

  // TMS navigation patterns, first cycle in bit 0
  localparam logic [PRE_W-1:0]  PAT_RESET    = 12'h7FF;
  localparam logic [PRE_IW-1:0] LEN_RESET    = 4'd12;
  localparam logic [PRE_W-1:0]  PAT_IR_ENTRY = 12'h003;
  localparam logic [PRE_IW-1:0] LEN_IR_ENTRY = 4'd4;
  localparam logic [PRE_W-1:0]  PAT_DR_ENTRY = 12'h001;
  localparam logic [PRE_IW-1:0] LEN_DR_ENTRY = 4'd3;
  localparam logic [PRE_W-1:0]  PAT_PAUSE    = 12'h035;
  localparam logic [PRE_IW-1:0] LEN_PAUSE    = 4'd7;

  typedef struct packed {
    logic [PRE_W-1:0]  pre_tms;
    logic [PRE_IW-1:0] pre_len;
    shift_kind_t       kind;
    logic [CNT_W-1:0]  shift_len;
    logic [DATA_W-1:0] word;
    logic              rd;
    logic              lastw;
    logic              post;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/jtss_front.sv =====
// Front end: takes commands, tracks the open data scan, builds cycle plans.
// Depends on jtss_pkg.
`default_nettype none
module jtss_front #(
  parameter int WORD_BITS       = 32,
  parameter int MAX_IDLE_CYCLES = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire [2:0]           action,
  input  wire [5:0]           bit_count,
  input  wire [31:0]          tdi_word,
  input  wire                 read_mode,
  input  wire                 last_word,
  input  wire [6:0]           idle_cycles,
  output logic                q_push,
  output jtss_pkg::cmd_t      q_cmd
);
  import jtss_pkg::*;

  logic             in_shift_dr;
  logic             in_shift_dr_next;
  logic             keep;
  logic [CNT_W-1:0] bits;
  logic [CNT_W-1:0] idle;

  always_comb begin
    bits = {1'b0, bit_count};
    if (bits == '0) begin
      bits = CNT_W'(1);
    end else if (bits > CNT_W'(WORD_BITS)) begin
      bits = CNT_W'(WORD_BITS);
    end
    idle = idle_cycles;
    if (idle > CNT_W'(MAX_IDLE_CYCLES)) begin
      idle = CNT_W'(MAX_IDLE_CYCLES);
    end
  end

  always_comb begin
    q_cmd.pre_tms   = '0;
    q_cmd.pre_len   = '0;
    q_cmd.kind      = SH_NONE;
    q_cmd.shift_len = bits;
    q_cmd.word      = tdi_word;
    q_cmd.rd        = read_mode;
    q_cmd.lastw     = last_word;
    q_cmd.post      = 1'b0;
    keep            = 1'b0;
    in_shift_dr_next = in_shift_dr;
    unique case (action)
      ACT_RESET: begin
        q_cmd.pre_tms    = PAT_RESET;
        q_cmd.pre_len    = LEN_RESET;
        keep             = 1'b1;
        in_shift_dr_next = 1'b0;
      end
      ACT_DR: begin
        if (!in_shift_dr) begin
          q_cmd.pre_tms = PAT_DR_ENTRY;
          q_cmd.pre_len = LEN_DR_ENTRY;
        end
        q_cmd.kind       = SH_DR;
        q_cmd.post       = last_word;
        keep             = 1'b1;
        in_shift_dr_next = !last_word;
      end
      ACT_IR: begin
        q_cmd.pre_tms = PAT_IR_ENTRY;
        q_cmd.pre_len = LEN_IR_ENTRY;
        q_cmd.kind    = SH_IR;
        q_cmd.post    = 1'b1;
        keep          = !in_shift_dr;
      end
      ACT_PAUSE: begin
        q_cmd.pre_tms = PAT_PAUSE;
        q_cmd.pre_len = LEN_PAUSE;
        keep          = !in_shift_dr;
      end
      ACT_IDLE: begin
        q_cmd.kind      = SH_IDLE;
        q_cmd.shift_len = idle;
        keep            = !in_shift_dr && (idle != '0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_shift_dr <= 1'b0;
    end else if (accept) begin
      in_shift_dr <= in_shift_dr_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jtss_cmd_queue.sv =====
// Short command queue between front and back ends.
// Depends on jtss_pkg.
`default_nettype none
module jtss_cmd_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_en,
  input  jtss_pkg::cmd_t      wr_cmd,
  output logic                full,
  input  wire                 rd_en,
  output jtss_pkg::cmd_t      rd_cmd,
  output logic                nonempty
);
  import jtss_pkg::*;

  cmd_t            store [Q_DEPTH];
  logic [Q_IW-1:0] wr_ptr;
  logic [Q_IW-1:0] rd_ptr;
  logic [Q_IW:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == (Q_IW+1)'(Q_DEPTH));
  assign nonempty = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_cmd   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_IW'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_IW'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Q_IW+1)'(do_wr) - (Q_IW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jtss_back.sv =====
// Back end: steps through one command plan, one TCK cycle per result beat.
// Depends on jtss_pkg.
`default_nettype none
module jtss_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_nonempty,
  input  jtss_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  wire                 pop,
  output logic                empty,
  output logic                tms_level,
  output logic                tdi_level,
  output logic                sample_tdo,
  output logic [4:0]          tdo_bit_position,
  output logic                last_cycle
);
  import jtss_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PRE,
    B_SHIFT,
    B_POST
  } bstate_t;

  bstate_t           state;
  cmd_t              cmd;
  logic [PRE_IW-1:0] pidx;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] word;
  logic              out_valid;
  logic              adv;
  logic              pre_end;
  logic              sh_end;

  assign empty   = !out_valid;
  assign adv     = !out_valid || pop;
  assign q_pop   = (state == B_IDLE) && q_nonempty;
  assign pre_end = (pidx == cmd.pre_len - 1'b1);
  assign sh_end  = (cnt == cmd.shift_len - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (adv) begin
            out_valid <= 1'b0;
          end
          if (q_nonempty) begin
            cmd   <= q_cmd;
            word  <= q_cmd.word;
            pidx  <= '0;
            cnt   <= '0;
            state <= (q_cmd.pre_len != '0) ? B_PRE : B_SHIFT;
          end
        end
        B_PRE: begin
          if (adv) begin
            out_valid        <= 1'b1;
            tms_level        <= cmd.pre_tms[pidx];
            tdi_level        <= 1'b1;
            sample_tdo       <= 1'b0;
            tdo_bit_position <= '0;
            last_cycle       <= pre_end && (cmd.kind == SH_NONE);
            pidx             <= pidx + 1'b1;
            if (pre_end) begin
              state <= (cmd.kind == SH_NONE) ? B_IDLE : B_SHIFT;
            end
          end
        end
        B_SHIFT: begin
          if (adv) begin
            out_valid        <= 1'b1;
            sample_tdo       <= (cmd.kind == SH_DR) && cmd.rd;
            tdo_bit_position <= (cmd.kind == SH_DR) ? cnt[POS_W-1:0] : '0;
            last_cycle       <= sh_end && !cmd.post;
            case (cmd.kind)
              SH_IR: begin
                tms_level <= sh_end;
                tdi_level <= word[0];
              end
              SH_DR: begin
                tms_level <= sh_end && cmd.lastw;
                tdi_level <= !cmd.rd && word[0];
              end
              default: begin
                tms_level <= 1'b0;
                tdi_level <= 1'b1;
              end
            endcase
            word <= word >> 1;
            cnt  <= cnt + 1'b1;
            pidx <= '0;
            if (sh_end) begin
              state <= cmd.post ? B_POST : B_IDLE;
            end
          end
        end
        B_POST: begin
          // exit to Run-Test/Idle: TMS 1 then 0
          if (adv) begin
            out_valid        <= 1'b1;
            tms_level        <= (pidx == '0);
            tdi_level        <= 1'b1;
            sample_tdo       <= 1'b0;
            tdo_bit_position <= '0;
            last_cycle       <= (pidx != '0);
            pidx             <= pidx + 1'b1;
            if (pidx != '0) begin
              state <= B_IDLE;
            end
          end
        end
        default: begin
          if (adv) begin
            out_valid <= 1'b0;
          end
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jtag_tap_scan_sequencer.sv =====
// JTAG TAP scan sequencer: command queue in, one result beat per TCK cycle out.
// Usage: push a command (reset, IR scan, DR chunk, DR pause, run-idle) when
// full is low. Each command expands into a run of result beats, one per TCK
// cycle: TMS and TDI levels, a TDO sample flag with its bit position, and
// last_cycle on the final beat of the command. Commands that produce no
// cycles (unknown codes, zero idle count, IR/pause/idle while a data scan is
// open) are taken and dropped.
// Results appear queue-fashion: while empty is low the oldest beat is on
// the ports; pop takes it. Within a command the back end produces one beat
// per clock while pop is held, and it passes through its idle state to load
// each plan. A pushed command is first written into the queue; the idle back
// end then loads its plan and, in its following state, registers its first
// beat. A two-entry command queue sits between front and back, so push is
// taken while the back end works until it fills. With pop low the current
// beat holds and the back end stops; commands keep entering until the queue is full.
// Reset (rst, synchronous) empties queue and output, and closes any data scan.
// Depends on jtss_pkg, jtss_front, jtss_cmd_queue, jtss_back and the
// assertion macro header.
`default_nettype none
`include "jtag_tap_scan_sequencer_assert.svh"
module jtag_tap_scan_sequencer #(
  parameter int WORD_BITS       = 32,
  parameter int MAX_IDLE_CYCLES = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire [2:0]   action,
  input  wire [5:0]   bit_count,
  input  wire [31:0]  tdi_word,
  input  wire         read_mode,
  input  wire         first_word,
  input  wire         last_word,
  input  wire [6:0]   idle_cycles,
  input  wire         pop,
  output logic        empty,
  output logic        tms_level,
  output logic        tdi_level,
  output logic        sample_tdo,
  output logic [4:0]  tdo_bit_position,
  output logic        last_cycle
);
  import jtss_pkg::*;

  logic accept;
  logic q_push;
  cmd_t f_cmd;
  cmd_t b_cmd;
  logic q_pop;
  logic q_nonempty;
  logic unused_first;

  // entry navigation follows the tracked scan state, not the first mark
  assign unused_first = first_word;
  assign accept       = push && !full;

  jtss_front #(
    .WORD_BITS       (WORD_BITS),
    .MAX_IDLE_CYCLES (MAX_IDLE_CYCLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .bit_count   (bit_count),
    .tdi_word    (tdi_word),
    .read_mode   (read_mode),
    .last_word   (last_word),
    .idle_cycles (idle_cycles),
    .q_push      (q_push),
    .q_cmd       (f_cmd)
  );

  jtss_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (f_cmd),
    .full     (full),
    .rd_en    (q_pop),
    .rd_cmd   (b_cmd),
    .nonempty (q_nonempty)
  );

  jtss_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_nonempty       (q_nonempty),
    .q_cmd            (b_cmd),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .tms_level        (tms_level),
    .tdi_level        (tdi_level),
    .sample_tdo       (sample_tdo),
    .tdo_bit_position (tdo_bit_position),
    .last_cycle       (last_cycle)
  );

  `JTSS_ASSERT_NR(a_reset_clear, clk, rst |=> (empty && !full), "reset left beats or full")
  `JTSS_ASSERT(a_read_tdi_low, clk, rst, (!empty && sample_tdo) |-> !tdi_level, "read beat drives TDI")
  `JTSS_ASSERT(a_sample_end, clk, rst, (!empty && sample_tdo && last_cycle) |-> !tms_level, "TMS high on open-scan end")

endmodule
`default_nettype wire

// ===== tb/jtss_tck_checker.sv =====
// Checker for the JTAG TAP scan sequencer: watches the command and TCK beat channels,
// expands each accepted command into its TCK beats and compares them in order.
// Depends on jtss_pkg for the action codes.
module jtss_tck_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire        full,
  input  wire [2:0]  action,
  input  wire [5:0]  bit_count,
  input  wire [31:0] tdi_word,
  input  wire        read_mode,
  input  wire        first_word,
  input  wire        last_word,
  input  wire [6:0]  idle_cycles,
  input  wire        pop,
  input  wire        empty,
  input  wire        tms_level,
  input  wire        tdi_level,
  input  wire        sample_tdo,
  input  wire [4:0]  tdo_bit_position,
  input  wire        last_cycle,
  output int         mismatches,
  output int         beats_pending
);
  import jtss_pkg::*;

  localparam int WORD_LEN = 32;
  localparam int IDLE_MAX = 64;
  localparam int RUN_MAX  = 64;

  // TMS navigation, first cycle in bit 0
  localparam logic [11:0] TMS_RESET    = 12'b0111_1111_1111;
  localparam int          RESET_LEN    = 12;
  localparam logic [11:0] TMS_IR_ENTRY = 12'b0011;
  localparam int          IR_ENTRY_LEN = 4;
  localparam logic [11:0] TMS_DR_ENTRY = 12'b001;
  localparam int          DR_ENTRY_LEN = 3;
  localparam logic [11:0] TMS_TO_IDLE  = 12'b01;
  localparam int          TO_IDLE_LEN  = 2;
  localparam logic [11:0] TMS_PAUSE    = 12'b011_0101;
  localparam int          PAUSE_LEN    = 7;

  typedef struct packed {
    logic       tms;
    logic       tdi;
    logic       smp;
    logic [4:0] pos;
    logic       lastc;
  } tck_beat_t;

  tck_beat_t tck_beats_due[$];
  tck_beat_t cmd_run [0:RUN_MAX-1];
  int        run_len;
  logic      shift_open;

  task automatic add_beat(input logic tms, input logic tdi, input logic smp,
                          input logic [4:0] pos);
    cmd_run[run_len] = {tms, tdi, smp, pos, 1'b0};
    run_len++;
  endtask

  task automatic add_nav(input logic [11:0] pat, input int len);
    for (int i = 0; i < len; i++) add_beat(pat[i], 1'b1, 1'b0, 5'd0);
  endtask

  task automatic expand_command(input logic [2:0] act, input logic [5:0] bc,
                                input logic [31:0] w, input logic rd,
                                input logic lw, input logic [6:0] ic);
    int nbits;
    int nidle;
    nbits = (bc == 6'd0) ? 1 : ((int'(bc) > WORD_LEN) ? WORD_LEN : int'(bc));
    nidle = (int'(ic) > IDLE_MAX) ? IDLE_MAX : int'(ic);
    run_len = 0;
    if (act == ACT_RESET) begin
      add_nav(TMS_RESET, RESET_LEN);
      shift_open = 1'b0;
    end else if (act == ACT_DR) begin
      if (!shift_open) add_nav(TMS_DR_ENTRY, DR_ENTRY_LEN);
      for (int i = 0; i < nbits; i++)
        add_beat(lw && (i == nbits - 1), rd ? 1'b0 : w[i], rd, 5'(i));
      if (lw) add_nav(TMS_TO_IDLE, TO_IDLE_LEN);
      shift_open = !lw;
    end else if (shift_open) begin
      // TAP parked in Shift-DR: anything but reset or a chunk is dropped
    end else if (act == ACT_IR) begin
      add_nav(TMS_IR_ENTRY, IR_ENTRY_LEN);
      for (int i = 0; i < nbits; i++) add_beat(i == nbits - 1, w[i], 1'b0, 5'd0);
      add_nav(TMS_TO_IDLE, TO_IDLE_LEN);
    end else if (act == ACT_PAUSE) begin
      add_nav(TMS_PAUSE, PAUSE_LEN);
    end else if (act == ACT_IDLE) begin
      for (int i = 0; i < nidle; i++) add_beat(1'b0, 1'b1, 1'b0, 5'd0);
    end
    if (run_len > 0) cmd_run[run_len-1].lastc = 1'b1;
    for (int i = 0; i < run_len; i++) tck_beats_due.push_back(cmd_run[i]);
  endtask

  initial begin
    mismatches    = 0;
    beats_pending = 0;
    shift_open    = 1'b0;
    run_len       = 0;
  end

  always @(posedge clk) begin
    tck_beat_t got;
    tck_beat_t want;
    if (rst) begin
      tck_beats_due.delete();
      shift_open = 1'b0;
    end else begin
      if (push && !full)
        expand_command(action, bit_count, tdi_word, read_mode, last_word, idle_cycles);
      if (pop && !empty) begin
        got = {tms_level, tdi_level, sample_tdo, tdo_bit_position, last_cycle};
        if (tck_beats_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected TCK beat, expected none, got tms=%b tdi=%b smp=%b pos=%0d last=%b",
                   $time, got.tms, got.tdi, got.smp, got.pos, got.lastc);
        end else begin
          want = tck_beats_due.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: TCK beat mismatch, expected tms=%b tdi=%b smp=%b pos=%0d last=%b",
                     $time, want.tms, want.tdi, want.smp, want.pos, want.lastc);
            $display("%0t:                      got tms=%b tdi=%b smp=%b pos=%0d last=%b",
                     $time, got.tms, got.tdi, got.smp, got.pos, got.lastc);
          end
        end
      end
    end
    beats_pending = tck_beats_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the JTAG TAP scan sequencer bench: clock, reset, command stimulus and
// a stalling beat receiver; checking is done by jtss_tck_checker.
// Depends on jtss_pkg, jtag_tap_scan_sequencer and jtss_tck_checker.
module tb_top;
  import jtss_pkg::*;

  localparam logic [2:0] ACT_CODE_MAX = 3'b111;

  // receiver stall modes
  localparam int POP_FREE       = 0;
  localparam int POP_COIN       = 1;
  localparam int POP_EVERY_N    = 2;
  localparam int POP_RARE_STALL = 3;

  localparam int HOLD_CYCLES = 400;
  localparam int USEFUL_CMDS = 175;

  typedef struct packed {
    logic [2:0]  act;
    logic [5:0]  bits;
    logic [31:0] word;
    logic        rd;
    logic        fw;
    logic        lw;
    logic [6:0]  idle;
  } tap_cmd_s;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  action;
  logic [5:0]  bit_count;
  logic [31:0] tdi_word;
  logic        read_mode;
  logic        first_word;
  logic        last_word;
  logic [6:0]  idle_cycles;
  logic        pop;
  logic        empty;
  logic        tms_level;
  logic        tdi_level;
  logic        sample_tdo;
  logic [4:0]  tdo_bit_position;
  logic        last_cycle;

  int fails;
  int pending;
  int burst_left;
  int hold_req;

  jtag_tap_scan_sequencer u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .bit_count(bit_count), .tdi_word(tdi_word), .read_mode(read_mode),
    .first_word(first_word), .last_word(last_word), .idle_cycles(idle_cycles),
    .pop(pop), .empty(empty), .tms_level(tms_level), .tdi_level(tdi_level),
    .sample_tdo(sample_tdo), .tdo_bit_position(tdo_bit_position),
    .last_cycle(last_cycle)
  );

  jtss_tck_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .bit_count(bit_count), .tdi_word(tdi_word), .read_mode(read_mode),
    .first_word(first_word), .last_word(last_word), .idle_cycles(idle_cycles),
    .pop(pop), .empty(empty), .tms_level(tms_level), .tdi_level(tdi_level),
    .sample_tdo(sample_tdo), .tdo_bit_position(tdo_bit_position),
    .last_cycle(last_cycle), .mismatches(fails), .beats_pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic tap_cmd_s mk_cmd(input logic [2:0] act, input logic [5:0] bits,
                                      input logic [31:0] word, input logic rd,
                                      input logic fw, input logic lw,
                                      input logic [6:0] idle);
    return {act, bits, word, rd, fw, lw, idle};
  endfunction

  function automatic tap_cmd_s rand_cmd();
    return mk_cmd(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
  endfunction

  // mostly short words so the run stays quick, with the odd full or clamped count
  function automatic logic [5:0] pick_bits();
    int r = $urandom_range(0, 19);
    if (r == 0) return 6'd0;
    if (r == 1) return 6'($urandom_range(33, 63));
    if (r < 9) return 6'($urandom_range(1, 8));
    return 6'($urandom_range(1, 32));
  endfunction

  function automatic logic [6:0] pick_idle();
    int r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'($urandom_range(65, 127));
    if (r == 2) return 7'($urandom_range(17, 64));
    return 7'($urandom_range(1, 16));
  endfunction

  // a command that the block drops while a data scan is open
  function automatic logic [2:0] pick_blocked_act();
    case ($urandom_range(0, 3))
      0: return ACT_IR;
      1: return ACT_PAUSE;
      2: return ACT_IDLE;
      default: return 3'($urandom_range(int'(ACT_IDLE) + 1, int'(ACT_CODE_MAX)));
    endcase
  endfunction

  // hold the command until taken, then maybe close the burst with a gap
  task automatic send(input tap_cmd_s c);
    @(negedge clk);
    action      <= c.act;
    bit_count   <= c.bits;
    tdi_word    <= c.word;
    read_mode   <= c.rd;
    first_word  <= c.fw;
    last_word   <= c.lw;
    idle_cycles <= c.idle;
    push        <= 1'b1;
    do @(posedge clk); while (full);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // receiver: stall pattern changes every so often; long hold-off on request
  initial begin
    int mode;
    int left;
    int n;
    int ph;
    int served;
    pop    = 1'b0;
    mode   = POP_FREE;
    left   = 0;
    n      = 2;
    ph     = 0;
    served = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req != served) begin
        served = hold_req;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(POP_FREE, POP_RARE_STALL);
          left = $urandom_range(20, 200);
          n    = $urandom_range(2, 8);
        end
        left--;
        ph++;
        case (mode)
          POP_FREE:    pop <= 1'b1;
          POP_COIN:    pop <= 1'($urandom_range(0, 1));
          POP_EVERY_N: pop <= (ph % n) == 0;
          default:     pop <= $urandom_range(0, 15) != 0;
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    tap_cmd_s c;
    int       nch;
    logic     rd;
    int       useful;
    int       p;
    int       holds;
    rst         = 1'b1;
    push        = 1'b0;
    action      = '0;
    bit_count   = '0;
    tdi_word    = '0;
    read_mode   = 1'b0;
    first_word  = 1'b0;
    last_word   = 1'b0;
    idle_cycles = '0;
    hold_req    = 0;
    burst_left  = $urandom_range(1, 24);
    useful      = 0;
    holds       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send(mk_cmd(ACT_RESET, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IR, 6'd32, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IR, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IR, 6'd63, 32'hA5A5_5A5A, 1'b1, 1'b1, 1'b1, 7'h7F));
    // chunk with no first mark still opens the scan
    send(mk_cmd(ACT_DR, 6'd32, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_DR, 6'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 7'd0));
    send(mk_cmd(ACT_IR, 6'd8, 32'h0000_00FF, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_PAUSE, 6'd8, 32'h0, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IDLE, 6'd8, 32'h0, 1'b0, 1'b0, 1'b0, 7'd10));
    send(mk_cmd(ACT_DR, 6'd33, 32'h5555_5555, 1'b0, 1'b0, 1'b1, 7'd0));
    send(mk_cmd(ACT_PAUSE, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IDLE, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IDLE, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd1));
    send(mk_cmd(ACT_IDLE, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd64));
    send(mk_cmd(ACT_IDLE, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'h7F));
    send(mk_cmd(ACT_DR, 6'd32, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 7'd0));
    send(mk_cmd(ACT_DR, 6'd5, 32'h0000_0015, 1'b0, 1'b1, 1'b0, 7'd0));
    send(mk_cmd(ACT_RESET, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd0));
    for (int a = int'(ACT_IDLE) + 1; a <= int'(ACT_CODE_MAX); a++) begin
      c = rand_cmd();
      c.act = 3'(a);
      send(c);
    end
    send(mk_cmd(ACT_DR, 6'd1, 32'h0000_0001, 1'b0, 1'b1, 1'b1, 7'd0));
    send(mk_cmd(ACT_IR, 6'd1, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 7'd0));
    send(mk_cmd(ACT_IDLE, 6'd0, 32'h0, 1'b0, 1'b0, 1'b0, 7'd65));

    // random
    while (useful < USEFUL_CMDS) begin
      if ((holds == 0 && useful >= 40) || (holds == 1 && useful >= 150)) begin
        hold_req++;
        holds++;
      end
      p = $urandom_range(0, 99);
      if (p < 35) begin
        nch = $urandom_range(1, 4);
        rd  = 1'($urandom_range(0, 1));
        for (int k = 0; k < nch; k++) begin
          c = rand_cmd();
          c.act  = ACT_DR;
          c.bits = pick_bits();
          c.rd   = ($urandom_range(0, 9) == 0) ? !rd : rd;
          c.fw   = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
          c.lw   = (k == nch - 1);
          send(c);
          useful++;
          if (k < nch - 1 && $urandom_range(0, 5) == 0) begin
            c = rand_cmd();
            c.act = pick_blocked_act();
            send(c);
          end
        end
      end else if (p < 55) begin
        c = rand_cmd();
        c.act  = ACT_IR;
        c.bits = pick_bits();
        send(c);
        useful++;
      end else if (p < 63) begin
        c = rand_cmd();
        c.act = ACT_PAUSE;
        send(c);
        useful++;
      end else if (p < 78) begin
        c = rand_cmd();
        c.act  = ACT_IDLE;
        c.idle = pick_idle();
        send(c);
        if (c.idle != 7'd0) useful++;
      end else if (p < 83) begin
        c = rand_cmd();
        c.act = ACT_RESET;
        send(c);
        useful++;
      end else if (p < 90) begin
        // scan left open, then abandoned by a TAP reset
        nch = $urandom_range(1, 2);
        for (int k = 0; k < nch; k++) begin
          c = rand_cmd();
          c.act  = ACT_DR;
          c.bits = pick_bits();
          c.lw   = 1'b0;
          send(c);
          useful++;
        end
        c = rand_cmd();
        c.act = ACT_RESET;
        send(c);
        useful++;
      end else begin
        send(rand_cmd());
      end
    end

    @(negedge clk);
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (fails == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
